// ===== src/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample rate divider calculator package
// Shared widths, constants and the lane record that travels down the divider
// chain.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

  localparam int RATE_W = 16;
  localparam int QW     = 7;
  localparam int RW_C   = 20;
  localparam int DW_C   = RATE_W + QW - 1;
  localparam int RW_F   = 23;
  localparam int DIV_W  = 21;
  localparam int DW_F   = DIV_W + QW - 1;

  localparam logic [RATE_W-1:0] RATE_MIN      = 16'd4000;
  localparam logic [RATE_W-1:0] RATE_MAX      = 16'd48000;
  localparam logic [RATE_W-1:0] RATE_SPLIT    = 16'd22000;
  localparam logic [RW_C-1:0]   HI_CLOCK_BASE = 20'd795500;
  localparam logic [RW_C-1:0]   LO_CLOCK_BASE = 20'd397700;
  localparam logic [RW_F-1:0]   FILTER_BASE   = 23'd7160000;
  localparam logic [6:0]        FILTER_MULT   = 7'd82;
  localparam logic [16:0]       RECIP_FIVE    = 17'd52429;
  localparam int                RECIP_SHIFT   = 18;
  localparam logic [7:0]        HI_CLOCK_FLAG = 8'h80;

  typedef struct packed {
    logic [RW_C-1:0]   rem_c;
    logic [DW_C-1:0]   den_c;
    logic [QW-1:0]     quo_c;
    logic [RW_F-1:0]   rem_f;
    logic [DW_F-1:0]   den_f;
    logic [QW-1:0]     quo_f;
    logic [RATE_W-1:0] rate;
    logic              hi;
  } lane_t;

endpackage

`default_nettype wire

// ===== src/sdc_prep.sv =====
// ----------------------------------------------------------------------------
// Operand preparation
// Clamps the rate, forms both rounded numerators and the filter divisor over
// three registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_prep (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  input  wire logic [sdc_pkg::RATE_W-1:0]  up_rate,
  output logic                             up_ready,
  output logic                             dn_valid,
  output sdc_pkg::lane_t                   dn_lane,
  input  wire logic                        dn_ready
);

  logic                        v1_r, v2_r, v3_r;
  logic                        rdy1, rdy2, rdy3;
  logic [sdc_pkg::RATE_W-1:0]  rate1_r, rate1_nxt;
  logic [sdc_pkg::RATE_W-1:0]  rate2_r;
  logic                        hi2_r, hi2_nxt;
  logic [sdc_pkg::RW_C-1:0]    num2_r, num2_nxt;
  logic [sdc_pkg::RATE_W-1:0]  scaled2_r, scaled2_nxt;
  logic [18:0]                 times9;
  logic [16:0]                 quarter;
  logic [33:0]                 prod5;
  logic [22:0]                 prod82;
  sdc_pkg::lane_t              lane3_r, lane3_nxt;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3_r;
  assign dn_lane  = lane3_r;

  always_comb begin
    if (up_rate < sdc_pkg::RATE_MIN) begin
      rate1_nxt = sdc_pkg::RATE_MIN;
    end else if (up_rate > sdc_pkg::RATE_MAX) begin
      rate1_nxt = sdc_pkg::RATE_MAX;
    end else begin
      rate1_nxt = up_rate;
    end
  end

  always_comb begin
    hi2_nxt     = rate1_r > sdc_pkg::RATE_SPLIT;
    num2_nxt    = (hi2_nxt ? sdc_pkg::HI_CLOCK_BASE : sdc_pkg::LO_CLOCK_BASE)
                  + {4'd0, 1'b0, rate1_r[sdc_pkg::RATE_W-1:1]};
    times9      = {rate1_r, 3'd0} + {3'd0, rate1_r};
    quarter     = times9[18:2];
    prod5       = {17'd0, quarter} * {17'd0, sdc_pkg::RECIP_FIVE};
    scaled2_nxt = prod5[sdc_pkg::RECIP_SHIFT +: sdc_pkg::RATE_W];
  end

  always_comb begin
    prod82          = {7'd0, scaled2_r} * {16'd0, sdc_pkg::FILTER_MULT};
    lane3_nxt.rem_c = num2_r;
    lane3_nxt.den_c = {rate2_r, {(sdc_pkg::QW-1){1'b0}}};
    lane3_nxt.quo_c = '0;
    lane3_nxt.rem_f = sdc_pkg::FILTER_BASE;
    lane3_nxt.den_f = {prod82[sdc_pkg::DIV_W-1:0], {(sdc_pkg::QW-1){1'b0}}};
    lane3_nxt.quo_f = '0;
    lane3_nxt.rate  = rate2_r;
    lane3_nxt.hi    = hi2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      rate1_r <= rate1_nxt;
    end
    if (rdy2) begin
      rate2_r   <= rate1_r;
      hi2_r     <= hi2_nxt;
      num2_r    <= num2_nxt;
      scaled2_r <= scaled2_nxt;
    end
    if (rdy3) begin
      lane3_r <= lane3_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/sdc_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step for both quotients: compare, subtract, shift the divisor
// right and pass the lane on.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_div_cell (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    up_valid,
  input  wire sdc_pkg::lane_t up_lane,
  output logic         up_ready,
  output logic         dn_valid,
  output sdc_pkg::lane_t dn_lane,
  input  wire logic    dn_ready
);

  logic                       valid_r;
  sdc_pkg::lane_t             lane_r, lane_nxt;
  logic                       ge_c, ge_f;
  logic [sdc_pkg::DW_C-1:0]   diff_c;
  logic [sdc_pkg::DW_F-1:0]   diff_f;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_lane  = lane_r;

  always_comb begin
    ge_c   = {{(sdc_pkg::DW_C-sdc_pkg::RW_C){1'b0}}, up_lane.rem_c} >= up_lane.den_c;
    ge_f   = {{(sdc_pkg::DW_F-sdc_pkg::RW_F){1'b0}}, up_lane.rem_f} >= up_lane.den_f;
    diff_c = {{(sdc_pkg::DW_C-sdc_pkg::RW_C){1'b0}}, up_lane.rem_c} - up_lane.den_c;
    diff_f = {{(sdc_pkg::DW_F-sdc_pkg::RW_F){1'b0}}, up_lane.rem_f} - up_lane.den_f;
    lane_nxt       = up_lane;
    lane_nxt.rem_c = ge_c ? diff_c[sdc_pkg::RW_C-1:0] : up_lane.rem_c;
    lane_nxt.rem_f = ge_f ? diff_f[sdc_pkg::RW_F-1:0] : up_lane.rem_f;
    lane_nxt.den_c = up_lane.den_c >> 1;
    lane_nxt.den_f = up_lane.den_f >> 1;
    lane_nxt.quo_c = {up_lane.quo_c[sdc_pkg::QW-2:0], ge_c};
    lane_nxt.quo_f = {up_lane.quo_f[sdc_pkg::QW-2:0], ge_f};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/sample_rate_divider_calc.sv =====
// ----------------------------------------------------------------------------
// Sample rate divider calculator
// Turns a requested sample rate into the clock and filter divider bytes.
// ----------------------------------------------------------------------------
// A new rate beat is taken every cycle while the output is not stalled, and
// each one yields one result beat: the preparation stages clamp the
// rate and form the operands, a chain of seven divider cells resolves one
// quotient bit of both divisions per cell, and one output register forms the
// bytes. Every stage holds its own valid bit, so empty stages fill up while
// the output waits.
`default_nettype none

module sample_rate_divider_calc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // requested_rate[15:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // clock_divider[7:0], filter_divider[15:8],
                                       // applied_rate[31:16]
);

  logic           valid_w [0:sdc_pkg::QW];
  logic           ready_w [0:sdc_pkg::QW];
  sdc_pkg::lane_t lane_w  [0:sdc_pkg::QW];

  logic           out_valid_r;
  logic [31:0]    out_data_r, out_data_nxt;
  logic [7:0]     neg_c, neg_f;
  logic [7:0]     clk_byte;

  sdc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_rate  (in_tdata),
    .up_ready (in_tready),
    .dn_valid (valid_w[0]),
    .dn_lane  (lane_w[0]),
    .dn_ready (ready_w[0])
  );

  for (genvar g = 0; g < sdc_pkg::QW; g++) begin : g_cell
    sdc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_w[g]),
      .up_lane  (lane_w[g]),
      .up_ready (ready_w[g]),
      .dn_valid (valid_w[g+1]),
      .dn_lane  (lane_w[g+1]),
      .dn_ready (ready_w[g+1])
    );
  end

  assign ready_w[sdc_pkg::QW] = !out_valid_r || out_tready;

  always_comb begin
    neg_c = 8'd0 - {1'b0, lane_w[sdc_pkg::QW].quo_c};
    neg_f = 8'd0 - {1'b0, lane_w[sdc_pkg::QW].quo_f};
    if (lane_w[sdc_pkg::QW].hi) begin
      clk_byte = sdc_pkg::HI_CLOCK_FLAG | neg_c;
    end else begin
      clk_byte = sdc_pkg::HI_CLOCK_FLAG - {1'b0, lane_w[sdc_pkg::QW].quo_c};
    end
    out_data_nxt = {lane_w[sdc_pkg::QW].rate, neg_f, clk_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready_w[sdc_pkg::QW]) begin
      out_valid_r <= valid_w[sdc_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ready_w[sdc_pkg::QW]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_rate_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:16] >= sdc_pkg::RATE_MIN &&
                    out_tdata[31:16] <= sdc_pkg::RATE_MAX))
    else $error("applied rate outside the clamp range");

  a_hi_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7] == (out_tdata[31:16] > sdc_pkg::RATE_SPLIT)))
    else $error("high-rate clock bit disagrees with the applied rate");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

endmodule

`default_nettype wire
